[sv/dotb_pkg.sv]
// Package for the decimal operand to binary converter.
// Holds transfer types, format and status codes, and shared decode functions.
// No dependencies.
package dotb_pkg;

    // Operand format codes
    localparam logic [3:0] TYPE_PACKED_U       = 4'd0;
    localparam logic [3:0] TYPE_PACKED_U_SLACK = 4'd1;
    localparam logic [3:0] TYPE_PACKED_S       = 4'd2;
    localparam logic [3:0] TYPE_PACKED_S_SLACK = 4'd3;
    localparam logic [3:0] TYPE_ZONED_U        = 4'd4;
    localparam logic [3:0] TYPE_ZONED_TR_HOLL  = 4'd5;
    localparam logic [3:0] TYPE_ZONED_TR_SEP   = 4'd6;
    localparam logic [3:0] TYPE_ZONED_LD_HOLL  = 4'd7;
    localparam logic [3:0] TYPE_ZONED_LD_SEP   = 4'd8;
    localparam logic [3:0] TYPE_ALPHA          = 4'd9;
    localparam logic [3:0] TYPE_BIN_U          = 4'd10;
    localparam logic [3:0] TYPE_BIN_S          = 4'd11;

    // Character and nibble constants
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [3:0] NIB_MINUS  = 4'hd;
    localparam logic [3:0] NIB_TEN    = 4'ha;
    localparam logic [3:0] NIB_NINE   = 4'h9;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATA = 2'd1,
        ST_SPEC_ERR = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0] operand_type;
        logic [8:0] operand_length;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] magnitude_high;
        logic [63:0] magnitude_low;
        logic        negative;
        status_t     status;
    } out_item_t;

    // Conversion state carried between bytes of one operand
    typedef struct packed {
        logic [63:0] accum_high;
        logic [63:0] accum_low;
        logic        sign_seen;
        logic        error_code;
        logic [8:0]  byte_position;
        logic        first_byte_msb;
    } conv_state_t;

    // Decoded Hollerith combined sign/digit byte
    typedef struct packed {
        logic       ok;
        logic       neg;
        logic [3:0] digit;
    } holl_t;

    // Maximum operand length per format; zero marks a reserved format
    function automatic logic [8:0] max_len(input logic [3:0] t);
        logic [8:0] m;
        case (t)
            TYPE_PACKED_U, TYPE_PACKED_U_SLACK,
            TYPE_PACKED_S, TYPE_PACKED_S_SLACK: m = 9'd19;
            TYPE_ZONED_U, TYPE_ZONED_TR_HOLL, TYPE_ZONED_TR_SEP,
            TYPE_ZONED_LD_HOLL, TYPE_ZONED_LD_SEP: m = 9'd38;
            TYPE_ALPHA: m = 9'd256;
            TYPE_BIN_U, TYPE_BIN_S: m = 9'd8;
            default: m = 9'd0;
        endcase
        return m;
    endfunction

    // acc * 10 + digit, modulo 2^128
    function automatic logic [127:0] mul10_add(input logic [127:0] a, input logic [3:0] d);
        return (a << 3) + (a << 1) + {124'd0, d};
    endfunction

    function automatic holl_t hollerith(input logic [7:0] b);
        holl_t h;
        h = '0;
        if (b >= 8'h31 && b <= CHAR_NINE) begin
            h.ok    = 1'b1;
            h.digit = b[3:0];
        end else if (b >= 8'h41 && b <= 8'h49) begin
            h.ok    = 1'b1;
            h.digit = b[3:0];
        end else if (b >= 8'h4a && b <= 8'h52) begin
            h.ok    = 1'b1;
            h.neg   = 1'b1;
            h.digit = 4'(b - 8'h49);
        end else if (b == 8'h26 || b == CHAR_ZERO || b == 8'h3c || b == 8'h7b) begin
            h.ok = 1'b1;
        end else if (b == 8'h21 || b == CHAR_MINUS || b == 8'h7d) begin
            h.ok  = 1'b1;
            h.neg = 1'b1;
        end
        return h;
    endfunction

endpackage

[sv/dotb_step.sv]
// One conversion step: folds one operand byte into the accumulator state.
// Pure combinational logic; depends on dotb_pkg.
module dotb_step
    import dotb_pkg::*;
(
    input  in_item_t    item,
    input  conv_state_t st,
    output conv_state_t st_next,
    output logic        emit,
    output out_item_t   result
);

    logic [3:0]   typ;
    logic [8:0]   len;
    logic [7:0]   bb;
    logic [3:0]   hi_n;
    logic [3:0]   lo_n;
    logic         first;
    logic         last;
    logic         spec_err;
    logic         empty;
    logic [9:0]   pos_inc;
    logic [127:0] acc;
    logic [127:0] acc_n;
    logic         sign_n;
    logic         err_n;
    logic         fbm_n;
    logic         char_ok;
    logic [3:0]   char_dig;
    logic [63:0]  sx;
    holl_t        hz;

    always_comb begin
        typ      = item.operand_type;
        len      = item.operand_length;
        bb       = item.data_byte;
        acc      = {st.accum_high, st.accum_low};
        acc_n    = acc;
        sign_n   = st.sign_seen;
        err_n    = st.error_code;
        first    = (st.byte_position == 9'd0);
        pos_inc  = {1'b0, st.byte_position} + 10'd1;
        last     = (pos_inc >= {1'b0, len});
        spec_err = (typ == TYPE_ALPHA) || (max_len(typ) == 9'd0) || (len > max_len(typ));
        empty    = (len == 9'd0);
        fbm_n    = first ? bb[7] : st.first_byte_msb;
        char_ok  = (bb >= CHAR_ZERO) && (bb <= CHAR_NINE);
        char_dig = bb[3:0];
        hz       = hollerith(bb);
        sx       = '0;

        // Slack nibble of the first packed byte is dropped
        if ((typ == TYPE_PACKED_U_SLACK || typ == TYPE_PACKED_S_SLACK) && first) begin
            hi_n = 4'd0;
        end else begin
            hi_n = bb[7:4];
        end
        lo_n = bb[3:0];

        // Per-format digit handling
        case (typ)
            TYPE_PACKED_U, TYPE_PACKED_U_SLACK,
            TYPE_PACKED_S, TYPE_PACKED_S_SLACK: begin
                if ((typ == TYPE_PACKED_S || typ == TYPE_PACKED_S_SLACK) && last) begin
                    if (lo_n == NIB_MINUS) begin
                        sign_n = 1'b1;
                    end else if (lo_n < NIB_TEN) begin
                        err_n = 1'b1;
                    end
                    if (hi_n > NIB_NINE) begin
                        err_n = 1'b1;
                    end else begin
                        acc_n = mul10_add(acc, hi_n);
                    end
                end else if (hi_n > NIB_NINE || lo_n > NIB_NINE) begin
                    err_n = 1'b1;
                end else begin
                    acc_n = mul10_add(mul10_add(acc, hi_n), lo_n);
                end
            end
            TYPE_ZONED_U: begin
                if (char_ok) begin
                    acc_n = mul10_add(acc, char_dig);
                end else begin
                    err_n = 1'b1;
                end
            end
            TYPE_ZONED_TR_HOLL, TYPE_ZONED_LD_HOLL: begin
                if ((typ == TYPE_ZONED_TR_HOLL && last) || (typ == TYPE_ZONED_LD_HOLL && first)) begin
                    if (hz.neg) begin
                        sign_n = 1'b1;
                    end
                    if (hz.ok) begin
                        acc_n = mul10_add(acc, hz.digit);
                    end else begin
                        err_n = 1'b1;
                    end
                end else if (char_ok) begin
                    acc_n = mul10_add(acc, char_dig);
                end else begin
                    err_n = 1'b1;
                end
            end
            TYPE_ZONED_TR_SEP, TYPE_ZONED_LD_SEP: begin
                if ((typ == TYPE_ZONED_TR_SEP && last) || (typ == TYPE_ZONED_LD_SEP && first)) begin
                    if (bb == CHAR_MINUS) begin
                        sign_n = 1'b1;
                    end else if (bb != CHAR_PLUS) begin
                        err_n = 1'b1;
                    end
                end else if (char_ok) begin
                    acc_n = mul10_add(acc, char_dig);
                end else begin
                    err_n = 1'b1;
                end
            end
            default: begin
                // binary formats: big-endian byte shift into the low half
                acc_n = {acc[127:64], acc[55:0], bb};
            end
        endcase

        // Signed binary with top bit set: sign-extend and negate
        if (typ == TYPE_BIN_S && fbm_n && last) begin
            sx = acc_n[63:0];
            if (len < 9'd8) begin
                sx = sx | (~64'd0 << {len[2:0], 3'b000});
            end
            acc_n  = {64'd0, ~sx + 64'd1};
            sign_n = 1'b1;
        end

        // Result selection
        emit   = spec_err || empty || last;
        result = '0;
        if (spec_err) begin
            result.status = ST_SPEC_ERR;
        end else if (empty) begin
            result.status = ST_OK;
        end else if (err_n) begin
            result.status = ST_BAD_DATA;
        end else begin
            result.status         = ST_OK;
            result.magnitude_high = acc_n[127:64];
            result.magnitude_low  = acc_n[63:0];
            result.negative       = sign_n && (acc_n != 128'd0);
        end

        // State returns to reset after every result
        if (emit) begin
            st_next = '0;
        end else begin
            st_next.accum_high     = acc_n[127:64];
            st_next.accum_low      = acc_n[63:0];
            st_next.sign_seen      = sign_n;
            st_next.error_code     = err_n;
            st_next.byte_position  = pos_inc[8:0];
            st_next.first_byte_msb = fbm_n;
        end
    end

endmodule

[sv/decimal_operand_to_binary_top.sv]
// Top level of the decimal operand to binary converter.
// m_valid rises once an operand's last byte has passed the input register and then the result register.
// Throughput: one byte per cycle; input register, a step of <= 2 x10 shift-adds, result register.
// A result waiting on m_ready stalls the next result-producing byte only.
// Reset (aresetn low, synchronous) empties both registers and clears the accumulator state.
// Depends on dotb_pkg and dotb_step.
module decimal_operand_to_binary_top
    import dotb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    conv_state_t st_reg;
    conv_state_t st_next;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        step_emit;
    out_item_t   step_result;
    logic        out_free;
    logic        advance;

    dotb_step u_step (
        .item    (in_item_reg),
        .st      (st_reg),
        .st_next (st_next),
        .emit    (step_emit),
        .result  (step_result)
    );

    // Handshake control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!step_emit || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    // Conversion state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && step_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_emit) begin
            out_item_reg <= step_result;
        end
    end

`ifndef SYNTHESIS
    // Error results carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_item_reg.status != ST_OK) |->
            (out_item_reg.magnitude_high == 64'd0) && (out_item_reg.magnitude_low == 64'd0)
            && !out_item_reg.negative)
        else $error("error result with nonzero value");

    // No negative zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_item_reg.negative |->
            (out_item_reg.magnitude_high != 64'd0) || (out_item_reg.magnitude_low != 64'd0))
        else $error("negative zero result");

    // State is cleared after each result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_emit |=> (st_reg == '0))
        else $error("state not cleared after result");

    // A pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("pending result lost");
`endif

endmodule

[tb/sv/tb_decimal_operand_to_binary_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for decimal_operand_to_binary_top: queued operand bytes, in-bench
// predictor of the packed/zoned/binary conversion, and an in-order result check.
// Depends on dotb_pkg and the converter RTL.
module tb_decimal_operand_to_binary_top;
    import dotb_pkg::*;

    localparam int TOTAL_ITEMS     = 1775;
    localparam int QUIET_TAIL      = 150;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int PACKED_MAX_LEN  = 19;
    localparam int ZONED_MAX_LEN   = 38;
    localparam int BINARY_MAX_LEN  = 8;
    localparam int LENGTH_FIELD_MAX = 511;
    localparam logic [3:0] TYPE_RESERVED_FIRST = 4'd12;
    localparam logic [3:0] TYPE_RESERVED_LAST  = 4'd15;

    typedef struct {
        in_item_t item;
        bit       hold;   // wait for all conversions to drain before this transfer
    } pending_byte_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    pending_byte_t operand_bytes[$];
    out_item_t     expected_conversions[$];
    int            mismatch_count = 0;
    int            stall_cycles   = 0;
    int            cycle_count    = 0;
    int            send_gap       = 0;
    int            recv_gap       = 0;

    // Predictor state for the operand in progress
    logic [127:0] acc;
    logic         neg_seen;
    logic         data_bad;
    logic         first_msb;
    logic [8:0]   byte_idx;

    decimal_operand_to_binary_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int length_limit(input logic [3:0] t);
        case (t)
            TYPE_PACKED_U, TYPE_PACKED_U_SLACK,
            TYPE_PACKED_S, TYPE_PACKED_S_SLACK: return PACKED_MAX_LEN;
            TYPE_ZONED_U, TYPE_ZONED_TR_HOLL, TYPE_ZONED_TR_SEP,
            TYPE_ZONED_LD_HOLL, TYPE_ZONED_LD_SEP: return ZONED_MAX_LEN;
            TYPE_BIN_U, TYPE_BIN_S: return BINARY_MAX_LEN;
            default: return 0;  // alphanumeric and reserved are rejected on type
        endcase
    endfunction

    function automatic void clear_conversion();
        acc       = '0;
        neg_seen  = 1'b0;
        data_bad  = 1'b0;
        first_msb = 1'b0;
        byte_idx  = '0;
    endfunction

    function automatic void add_digit(input logic [3:0] d);
        acc = acc * 128'd10 + 128'(d);
    endfunction

    function automatic void take_char(input logic [7:0] b);
        if (b < CHAR_ZERO || b > CHAR_NINE)
            data_bad = 1'b1;
        else
            add_digit(b[3:0]);
    endfunction

    // Combined sign/digit character; -1 when the byte is not a legal one
    function automatic int holl_digit(input logic [7:0] b);
        if (b >= 8'h31 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h49) return int'(b) - 'h40;
        if (b >= 8'h4a && b <= 8'h52) begin
            neg_seen = 1'b1;
            return int'(b) - 'h49;
        end
        if (b == 8'h26 || b == 8'h30 || b == 8'h3c || b == 8'h7b) return 0;
        if (b == 8'h21 || b == 8'h2d || b == 8'h7d) begin
            neg_seen = 1'b1;
            return 0;
        end
        return -1;
    endfunction

    // Absorb one operand byte; returns 1 with the conversion when it completes
    function automatic bit convert_byte(input in_item_t it, output out_item_t res);
        logic [3:0]  t;
        logic [7:0]  b;
        logic [3:0]  hi_n;
        logic [3:0]  lo_n;
        logic [63:0] v;
        int          len;
        int          lim;
        int          d;
        bit          last;
        t   = it.operand_type;
        b   = it.data_byte;
        len = int'(it.operand_length);
        lim = length_limit(t);
        res = '0;
        if (t == TYPE_ALPHA || lim == 0 || len > lim) begin
            clear_conversion();
            res.status = ST_SPEC_ERR;
            return 1'b1;
        end
        if (len == 0) begin
            clear_conversion();
            res.status = ST_OK;
            return 1'b1;
        end
        last = (int'(byte_idx) + 1 >= len);
        if (byte_idx == 0)
            first_msb = b[7];

        case (t)
            TYPE_PACKED_U, TYPE_PACKED_U_SLACK, TYPE_PACKED_S, TYPE_PACKED_S_SLACK: begin
                // slack nibble is dropped, even when the first byte carries the sign
                if ((t == TYPE_PACKED_U_SLACK || t == TYPE_PACKED_S_SLACK) && byte_idx == 0)
                    b[7:4] = 4'h0;
                hi_n = b[7:4];
                lo_n = b[3:0];
                if ((t == TYPE_PACKED_S || t == TYPE_PACKED_S_SLACK) && last) begin
                    if (lo_n == NIB_MINUS)
                        neg_seen = 1'b1;
                    else if (lo_n < NIB_TEN)
                        data_bad = 1'b1;
                    if (hi_n > NIB_NINE)
                        data_bad = 1'b1;
                    else
                        add_digit(hi_n);
                end else if (hi_n > NIB_NINE || lo_n > NIB_NINE) begin
                    data_bad = 1'b1;
                end else begin
                    add_digit(hi_n);
                    add_digit(lo_n);
                end
            end
            TYPE_ZONED_TR_HOLL, TYPE_ZONED_LD_HOLL: begin
                if ((t == TYPE_ZONED_TR_HOLL && last) ||
                    (t == TYPE_ZONED_LD_HOLL && byte_idx == 0)) begin
                    d = holl_digit(b);
                    if (d < 0)
                        data_bad = 1'b1;
                    else
                        add_digit(4'(d));
                end else begin
                    take_char(b);
                end
            end
            TYPE_ZONED_TR_SEP, TYPE_ZONED_LD_SEP: begin
                if ((t == TYPE_ZONED_TR_SEP && last) ||
                    (t == TYPE_ZONED_LD_SEP && byte_idx == 0)) begin
                    if (b == CHAR_MINUS)
                        neg_seen = 1'b1;
                    else if (b != CHAR_PLUS)
                        data_bad = 1'b1;
                end else begin
                    take_char(b);
                end
            end
            TYPE_BIN_U, TYPE_BIN_S: acc[63:0] = {acc[55:0], b};
            default: take_char(b);
        endcase

        if (!last) begin
            byte_idx = byte_idx + 9'd1;
            return 1'b0;
        end

        // two's complement binary: sign-extend from the operand width, then negate
        if (t == TYPE_BIN_S && first_msb) begin
            v = acc[63:0];
            if (len < 8)
                v = v | (~64'd0 << (8 * len));
            acc      = {64'd0, ~v + 64'd1};
            neg_seen = 1'b1;
        end
        if (data_bad) begin
            res.status = ST_BAD_DATA;
        end else begin
            res.magnitude_high = acc[127:64];
            res.magnitude_low  = acc[63:0];
            res.negative       = neg_seen && (acc != '0);
            res.status         = ST_OK;
        end
        clear_conversion();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [3:0] pick_valid_type();
        logic [3:0] t;
        t = 4'($urandom_range(TYPE_PACKED_U, TYPE_BIN_S - 4'd1));
        if (t >= TYPE_ALPHA)
            t = t + 4'd1;   // skip alphanumeric
        return t;
    endfunction

    // Mostly short operands, now and then the longest one allowed
    function automatic int pick_length(input logic [3:0] t);
        int lim;
        int r;
        lim = length_limit(t);
        r   = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, (lim < 6) ? lim : 6);
        else if (r < 9)
            return $urandom_range(1, lim);
        return lim;
    endfunction

    function automatic logic [7:0] digit_char();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] sign_char();
        return $urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS;
    endfunction

    function automatic logic [7:0] holl_char();
        logic [7:0] plain_zero[4] = '{8'h26, 8'h30, 8'h3c, 8'h7b};
        logic [7:0] minus_zero[3] = '{8'h21, 8'h2d, 8'h7d};
        case ($urandom_range(0, 4))
            0: return 8'h31 + 8'($urandom_range(0, 8));
            1: return 8'h41 + 8'($urandom_range(0, 8));
            2: return 8'h4a + 8'($urandom_range(0, 8));
            3: return plain_zero[$urandom_range(0, 3)];
            default: return minus_zero[$urandom_range(0, 2)];
        endcase
    endfunction

    // A well-formed byte for position idx of an operand of this type and length
    function automatic logic [7:0] plausible_byte(input logic [3:0] t, input int idx,
                                                  input int len);
        logic [7:0] b;
        bit         first;
        bit         last;
        first = (idx == 0);
        last  = (idx == len - 1);
        case (t)
            TYPE_PACKED_U, TYPE_PACKED_U_SLACK, TYPE_PACKED_S, TYPE_PACKED_S_SLACK: begin
                b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
                if ((t == TYPE_PACKED_S || t == TYPE_PACKED_S_SLACK) && last)
                    b[3:0] = $urandom_range(0, 1) ? NIB_MINUS : 4'($urandom_range(10, 15));
                if ((t == TYPE_PACKED_U_SLACK || t == TYPE_PACKED_S_SLACK) && first)
                    b[7:4] = 4'($urandom);
            end
            TYPE_ZONED_TR_HOLL: b = last ? holl_char() : digit_char();
            TYPE_ZONED_LD_HOLL: b = first ? holl_char() : digit_char();
            TYPE_ZONED_TR_SEP:  b = last ? sign_char() : digit_char();
            TYPE_ZONED_LD_SEP:  b = first ? sign_char() : digit_char();
            TYPE_BIN_U, TYPE_BIN_S: b = 8'($urandom);
            default: b = digit_char();
        endcase
        return b;
    endfunction

    task automatic queue_byte(input logic [3:0] t, input int len, input logic [7:0] b,
                              input bit hold);
        pending_byte_t p;
        p.item.operand_type   = t;
        p.item.operand_length = 9'(len);
        p.item.data_byte      = b;
        p.hold                = hold;
        operand_bytes.push_back(p);
    endtask

    // noise: 0 clean, 1 one garbled byte, 2 every byte random
    task automatic queue_operand(input logic [3:0] t, input int len, input int noise,
                                 input bit hold);
        int bad_at;
        bad_at = (noise == 1) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++)
            queue_byte(t, len, (noise == 2 || i == bad_at) ? 8'($urandom)
                                                           : plausible_byte(t, i, len),
                       hold && i == 0);
    endtask

    // Bad type or length over the limit: one transfer, specification error
    task automatic queue_rejected(input bit hold);
        logic [3:0] t;
        int         len;
        if ($urandom_range(0, 1)) begin
            t   = ($urandom_range(0, 2) == 0) ? TYPE_ALPHA
                : 4'($urandom_range(TYPE_RESERVED_FIRST, TYPE_RESERVED_LAST));
            len = $urandom_range(0, LENGTH_FIELD_MAX);
        end else begin
            t   = pick_valid_type();
            len = $urandom_range(length_limit(t) + 1, LENGTH_FIELD_MAX);
        end
        queue_byte(t, len, 8'($urandom), hold);
    endtask

    function automatic bit idling_allowed();
        return operand_bytes.size() > QUIET_TAIL && cycle_count[8:7] != 2'b11;
    endfunction

    // ------------------------------------------------------------------
    // Driver: predicts on each input transfer, then presents the next byte
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pending_byte_t nxt;
        out_item_t     res;
        logic          valid_next;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
            clear_conversion();
        end else begin
            valid_next = s_valid;
            if (s_valid && s_ready) begin
                if (convert_byte(s_item, res))
                    expected_conversions.push_back(res);
                valid_next = 1'b0;
            end
            if (!valid_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (operand_bytes.size() != 0 &&
                             !(operand_bytes[0].hold && expected_conversions.size() != 0)) begin
                    nxt = operand_bytes.pop_front();
                    s_item <= nxt.item;
                    valid_next = 1'b1;
                    if (idling_allowed() && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 3);
                end
            end
            s_valid <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_conversions.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with none expected: high=%h low=%h neg=%b status=%0d",
                             $time, m_item.magnitude_high, m_item.magnitude_low,
                             m_item.negative, m_item.status);
                end else begin
                    want = expected_conversions.pop_front();
                    if (m_item.magnitude_high !== want.magnitude_high ||
                        m_item.magnitude_low !== want.magnitude_low ||
                        m_item.negative !== want.negative ||
                        m_item.status !== want.status) begin
                        mismatch_count++;
                        $display({"%0t: mismatch: expected high=%h low=%h neg=%b status=%0d,",
                                  " got high=%h low=%h neg=%b status=%0d"},
                                 $time, want.magnitude_high, want.magnitude_low,
                                 want.negative, want.status, m_item.magnitude_high,
                                 m_item.magnitude_low, m_item.negative, m_item.status);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 3);
            end
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [3:0] t;
        logic [3:0] t2;
        int         len;
        int         len2;
        int         k;
        int         r;
        int         next_hold_at;
        bit         hold;

        // Directed: rejected types and lengths, empty operand
        queue_byte(TYPE_ALPHA, 5, 8'h00, 1'b0);
        queue_byte(TYPE_RESERVED_LAST, LENGTH_FIELD_MAX, 8'hff, 1'b0);
        queue_byte(TYPE_PACKED_U, PACKED_MAX_LEN + 1, 8'h12, 1'b0);
        queue_byte(TYPE_BIN_U, 0, 8'hff, 1'b0);
        // packed: plain, negative, slack byte that is also the sign (minus zero)
        queue_byte(TYPE_PACKED_U, 1, 8'h99, 1'b0);
        queue_byte(TYPE_PACKED_S, 1, 8'h9d, 1'b0);
        queue_byte(TYPE_PACKED_S_SLACK, 1, 8'hfd, 1'b0);
        queue_byte(TYPE_PACKED_U_SLACK, 2, 8'hf1, 1'b0);
        queue_byte(TYPE_PACKED_U_SLACK, 2, 8'h23, 1'b0);
        // zoned: separate and combined signs, trailing and leading
        queue_byte(TYPE_ZONED_TR_SEP, 2, 8'h35, 1'b0);
        queue_byte(TYPE_ZONED_TR_SEP, 2, CHAR_MINUS, 1'b0);
        queue_byte(TYPE_ZONED_LD_SEP, 2, CHAR_PLUS, 1'b0);
        queue_byte(TYPE_ZONED_LD_SEP, 2, 8'h37, 1'b0);
        queue_byte(TYPE_ZONED_TR_HOLL, 2, 8'h31, 1'b0);
        queue_byte(TYPE_ZONED_TR_HOLL, 2, 8'h7d, 1'b0);
        queue_byte(TYPE_ZONED_LD_HOLL, 1, 8'h52, 1'b0);
        // bad digit in the operand's last byte
        queue_byte(TYPE_ZONED_U, 2, 8'h34, 1'b0);
        queue_byte(TYPE_ZONED_U, 2, 8'h78, 1'b0);
        // binary
        queue_byte(TYPE_BIN_S, 1, 8'h80, 1'b0);
        queue_byte(TYPE_BIN_U, 2, 8'hff, 1'b0);
        queue_byte(TYPE_BIN_U, 2, 8'hff, 1'b0);
        // partial operand abandoned by a reserved type
        queue_byte(TYPE_ZONED_U, 3, 8'h31, 1'b0);
        queue_byte(TYPE_RESERVED_FIRST, 1, 8'h00, 1'b0);
        queue_byte(TYPE_BIN_S, 2, 8'hff, 1'b0);
        queue_byte(TYPE_BIN_S, 2, 8'hfe, 1'b0);

        // Random: mostly well-formed operands, plus rejects and broken sequences
        next_hold_at = operand_bytes.size();
        while (operand_bytes.size() < TOTAL_ITEMS) begin
            hold = (operand_bytes.size() >= next_hold_at);
            if (hold)
                next_hold_at = operand_bytes.size() + $urandom_range(200, 500);
            r = $urandom_range(0, 99);
            t = pick_valid_type();
            if (r < 70) begin
                queue_operand(t, pick_length(t), ($urandom_range(0, 7) == 0) ? 1 : 0, hold);
            end else if (r < 74) begin
                queue_operand(t, pick_length(t), 2, hold);
            end else if (r < 82) begin
                queue_rejected(hold);
            end else if (r < 86) begin
                queue_byte(t, 0, 8'($urandom), hold);
            end else if (r < 94) begin
                // operand cut short by a reject or an empty operand
                len = $urandom_range(2, length_limit(t));
                k   = $urandom_range(1, len - 1);
                for (int i = 0; i < k; i++)
                    queue_byte(t, len, plausible_byte(t, i, len), hold && i == 0);
                if ($urandom_range(0, 1))
                    queue_rejected(1'b0);
                else
                    queue_byte(pick_valid_type(), 0, 8'($urandom), 1'b0);
            end else begin
                // type and length change partway through an operand
                len  = $urandom_range(2, length_limit(t));
                k    = $urandom_range(1, len - 1);
                t2   = pick_valid_type();
                len2 = $urandom_range(1, length_limit(t2));
                for (int i = 0; i < k; i++)
                    queue_byte(t, len, plausible_byte(t, i, len), hold && i == 0);
                for (int i = 0; i < ((len2 > k + 1) ? len2 - k : 1); i++)
                    queue_byte(t2, len2, plausible_byte(t2, k + i, len2), 1'b0);
            end
        end

        while ((operand_bytes.size() != 0 || s_valid || expected_conversions.size() != 0) &&
               stall_cycles < STALL_LIMIT)
            @(negedge aclk);

        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("tb_decimal_operand_to_binary_top: done, errors");
        end else begin
            repeat (DRAIN_CYCLES) @(negedge aclk);
            if (mismatch_count == 0 && expected_conversions.size() == 0)
                $display("tb_decimal_operand_to_binary_top: done, clean");
            else
                $display("tb_decimal_operand_to_binary_top: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
sv/dotb_pkg.sv
sv/dotb_step.sv
sv/decimal_operand_to_binary_top.sv
tb/sv/tb_decimal_operand_to_binary_top.sv
